@@ hdl/gnrs_pkg.sv @@
// Shared types and constants for the growing-need roulette selector.
// No dependencies; the interfaces and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package gnrs_pkg;

    // Field widths
    localparam int LEVEL_W  = 32;
    localparam int TOTAL_W  = 35;
    localparam int TIMER_W  = 17;
    localparam int DELTA_W  = 10;
    localparam int RAND_W   = 32;
    localparam int RATE_W   = 8;
    localparam int SLOT_W   = 3;
    localparam int PERIOD_W = 16;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE_TABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS  = 1'd1;

    // Register reset values
    localparam logic [CFG_W-1:0]    RATE_TABLE_RESET = 64'h0040_300D_3326_6040;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 16'd3000;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [TOTAL_W-1:0] total_t;

endpackage

`default_nettype wire

@@ hdl/gnrs_if.sv @@
// Valid/ready channel interfaces for the selector: tick requests, results and
// configuration writes. Depends on gnrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Tick request channel
interface gnrs_in_if;
    import gnrs_pkg::*;
    logic                valid;
    logic                ready;
    logic [DELTA_W-1:0]  delta_ms;
    logic [RAND_W-1:0]   random_word;

    modport source (output valid, delta_ms, random_word, input ready);
    modport sink   (input valid, delta_ms, random_word, output ready);
endinterface

// Result channel
interface gnrs_out_if;
    import gnrs_pkg::*;
    logic                valid;
    logic                ready;
    logic                selected;
    logic [SLOT_W-1:0]   chosen_slot;
    logic [LEVEL_W-1:0]  chosen_level;

    modport source (output valid, selected, chosen_slot, chosen_level, input ready);
    modport sink   (input valid, selected, chosen_slot, chosen_level, output ready);
endinterface

// Configuration write channel
interface gnrs_cfg_if;
    import gnrs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_W-1:0]      reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

`default_nettype wire

@@ hdl/growing_need_roulette_selector.sv @@
// Growing-need roulette selector: per-slot need levels, period timer and
// proportionate draw. Depends on gnrs_pkg and the interfaces in gnrs_if.sv.
//
// Usage:
//   item_in    - tick request: delta_ms elapsed and a 32-bit random word.
//   result_out - exactly one result per tick: selected, chosen_slot and
//                chosen_level (all zero when no slot was picked).
//   cfg        - register writes (0: rate_table, 1: period_ms); always ready.
//   Writes are expected only while no tick is in flight.
// Timing: one tick is in work at a time and item_in.ready is low meanwhile.
//   Growth visits the slots in turn, a multiply state and an add state each, through
//   the shared multiplier; then a timer state and a hand-off state follow. A draw
//   adds a multiply state and a sum state, then walks the slots up to the pick or
//   the last slot. The next tick can be taken in the cycle after the result loads.
//   The result sits in an output register; the next tick is accepted while it
//   waits, and a finished tick holds in its last step until that register
//   frees up when result_out stalls.
// Reset: levels, total and timer clear; rate_table and period_ms return to
//   their defaults; no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module growing_need_roulette_selector #(
    parameter int SLOT_COUNT = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    gnrs_in_if.sink     item_in,
    gnrs_out_if.source  result_out,
    gnrs_cfg_if.sink    cfg
);
    import gnrs_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_GROW_MUL = 3'd1;
    localparam logic [2:0] ST_GROW_ADD = 3'd2;
    localparam logic [2:0] ST_TIMER    = 3'd3;
    localparam logic [2:0] ST_DRAW_MUL = 3'd4;
    localparam logic [2:0] ST_DRAW_SUM = 3'd5;
    localparam logic [2:0] ST_WALK     = 3'd6;
    localparam logic [2:0] ST_FIN      = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [DELTA_W-1:0]  delta_reg, delta_next;
    logic [RAND_W-1:0]   rnd_reg, rnd_next;
    logic [CFG_W-1:0]    rate_table_reg, rate_table_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    level_t              level_reg [SLOT_COUNT];
    level_t              level_wdata;
    logic                level_we;
    total_t              total_reg, total_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [63:0]         mul_reg, mul_next;
    total_t              draw_reg, draw_next;
    logic                res_sel_reg, res_sel_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    level_t              res_level_reg, res_level_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_sel_reg, out_sel_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    level_t              out_level_reg, out_level_next;

    // Shared datapath signals
    logic [31:0]         mul_a, mul_b;
    level_t              cur_level;
    logic [RATE_W-1:0]   cur_rate;
    logic [LEVEL_W:0]    grow_sum;
    level_t              grow_level;
    logic [TIMER_W:0]    timer_sum;
    logic [TIMER_W-1:0]  timer_sat;
    logic                timer_fire;
    total_t              hi_prod;
    total_t              cur_level_ext;
    logic                in_take, out_take, cfg_take;

    assign item_in.ready = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign in_take       = item_in.valid && item_in.ready;
    assign cfg_take      = cfg.valid;
    assign out_take      = out_valid_reg && result_out.ready;

    assign result_out.valid        = out_valid_reg;
    assign result_out.selected     = out_sel_reg;
    assign result_out.chosen_slot  = out_slot_reg;
    assign result_out.chosen_level = out_level_reg;

    // Slot under the walking index
    assign cur_level     = level_reg[idx_reg];
    assign cur_rate      = rate_table_reg[RATE_W*idx_reg +: RATE_W];
    assign cur_level_ext = TOTAL_W'(cur_level);

    // Shared multiplier operands: rate*delta during growth, total*random for draw
    always_comb
    begin
        if (state_reg == ST_GROW_MUL)
        begin
            mul_a = 32'(cur_rate);
            mul_b = 32'(delta_reg);
        end
        else
        begin
            mul_a = total_reg[31:0];
            mul_b = rnd_reg;
        end
    end

    // Saturating level growth
    assign grow_sum   = {1'b0, cur_level} + (LEVEL_W+1)'(mul_reg[DELTA_W+RATE_W-1:0]);
    assign grow_level = grow_sum[LEVEL_W] ? '1 : grow_sum[LEVEL_W-1:0];

    // Saturating timer and period compare
    assign timer_sum  = {1'b0, timer_reg} + (TIMER_W+1)'(delta_reg);
    assign timer_sat  = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
    assign timer_fire = (timer_sat >= TIMER_W'(period_reg));

    // Upper total bits times random word, by shift-add over three bits
    assign hi_prod = (total_reg[32] ? TOTAL_W'(rnd_reg)         : '0)
                   + (total_reg[33] ? (TOTAL_W'(rnd_reg) << 1)  : '0)
                   + (total_reg[34] ? (TOTAL_W'(rnd_reg) << 2)  : '0);

    // Sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        delta_next      = delta_reg;
        rnd_next        = rnd_reg;
        total_next      = total_reg;
        timer_next      = timer_reg;
        mul_next        = mul_reg;
        draw_next       = draw_reg;
        res_sel_next    = res_sel_reg;
        res_slot_next   = res_slot_reg;
        res_level_next  = res_level_reg;
        level_we        = 1'b0;
        level_wdata     = grow_level;
        out_valid_next  = out_take ? 1'b0 : out_valid_reg;
        out_sel_next    = out_sel_reg;
        out_slot_next   = out_slot_reg;
        out_level_next  = out_level_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    delta_next     = item_in.delta_ms;
                    rnd_next       = item_in.random_word;
                    idx_next       = '0;
                    res_sel_next   = 1'b0;
                    res_slot_next  = '0;
                    res_level_next = '0;
                    state_next     = ST_GROW_MUL;
                end
            end
            ST_GROW_MUL:
            begin
                mul_next   = mul_a * mul_b;
                state_next = ST_GROW_ADD;
            end
            ST_GROW_ADD:
            begin
                level_we    = 1'b1;
                level_wdata = grow_level;
                total_next  = total_reg + TOTAL_W'(grow_level - cur_level);
                if (idx_reg == LAST_SLOT)
                begin
                    idx_next   = '0;
                    state_next = ST_TIMER;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_GROW_MUL;
                end
            end
            ST_TIMER:
            begin
                if (timer_fire)
                begin
                    timer_next = timer_sat - TIMER_W'(period_reg);
                    state_next = (total_reg != '0) ? ST_DRAW_MUL : ST_FIN;
                end
                else
                begin
                    timer_next = timer_sat;
                    state_next = ST_FIN;
                end
            end
            ST_DRAW_MUL:
            begin
                mul_next   = mul_a * mul_b;
                state_next = ST_DRAW_SUM;
            end
            ST_DRAW_SUM:
            begin
                draw_next  = hi_prod + TOTAL_W'(mul_reg[63:32]);
                idx_next   = '0;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (draw_reg < cur_level_ext)
                begin
                    res_sel_next   = 1'b1;
                    res_slot_next  = SLOT_W'(idx_reg);
                    res_level_next = cur_level;
                    level_we       = 1'b1;
                    level_wdata    = '0;
                    total_next     = total_reg - cur_level_ext;
                    state_next     = ST_FIN;
                end
                else
                begin
                    draw_next = draw_reg - cur_level_ext;
                    if (idx_reg == LAST_SLOT)
                        state_next = ST_FIN;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                // Hand off once the output register is free
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_sel_next   = res_sel_reg;
                    out_slot_next  = res_slot_reg;
                    out_level_next = res_level_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration register decode
    always_comb
    begin
        rate_table_next = rate_table_reg;
        period_next     = period_reg;
        if (cfg_take)
        begin
            unique case (cfg.reg_index)
                REG_RATE_TABLE: rate_table_next = cfg.reg_data;
                REG_PERIOD_MS:  period_next     = cfg.reg_data[PERIOD_W-1:0];
                default:        rate_table_next = rate_table_reg;
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            rate_table_reg <= RATE_TABLE_RESET;
            period_reg     <= PERIOD_RESET;
            total_reg      <= '0;
            timer_reg      <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
                level_reg[i] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            rate_table_reg <= rate_table_next;
            period_reg     <= period_next;
            total_reg      <= total_next;
            timer_reg      <= timer_next;
            out_valid_reg  <= out_valid_next;
            if (level_we)
                level_reg[idx_reg] <= level_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        delta_reg     <= delta_next;
        rnd_reg       <= rnd_next;
        mul_reg       <= mul_next;
        draw_reg      <= draw_next;
        res_sel_reg   <= res_sel_next;
        res_slot_reg  <= res_slot_next;
        res_level_reg <= res_level_next;
        out_sel_reg   <= out_sel_next;
        out_slot_reg  <= out_slot_next;
        out_level_reg <= out_level_next;
    end

endmodule

`default_nettype wire
